### hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the text console writer
// used by every module of the block but tcw_ram; depends on nothing

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W   = $clog2(CELLS);
  localparam int POS_W    = $clog2(CELLS + COLUMNS);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int CELL_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int ACTION_W = 2;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = ACTION_W;
  localparam int M_TDATA_W = 32;
  localparam int M_FIELD_W = CURSOR_W + 2 * BYTE_W + 1;
  localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

  localparam logic [BYTE_W-1:0] NL_CODE = 8'd10;
  localparam logic [BYTE_W-1:0] CR_CODE = 8'd13;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SET   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_CLEAR,
    CMD_SET,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_W-1:0]  char_code;
    logic [BYTE_W-1:0]  colour;
    logic [POS_W-1:0]   pos;       // saturated cell index
    logic               in_range;
  } cmd_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [BYTE_W-1:0]   cell_char;
    logic [BYTE_W-1:0]   cell_colour;
    logic                scrolled;
  } res_t;

endpackage

### hdl/text_console_writer.sv
`timescale 1ns / 1ps
// text console writer: an item is queued in tcw_front, then popped by tcw_back; put, newline
// and return register their result on the pop, read waits for the registered ram data, set cursor
// runs a row subtraction loop; a scroll and a clear pass over the store, one ram cell a cycle
// throughput: one plain character per cycle while no scroll runs and the result side accepts,
// set by the single ram write port; after rst a clearing pass zeros every cell, no item taken then
// depends on tcw_pkg, tcw_front, tcw_back, tcw_ram

module text_console_writer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,  // char_code, colour, cell_index, zero pad
  input  logic [tcw_pkg::S_TUSER_W-1:0] s_tuser,  // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tcw_pkg::M_TDATA_W-1:0] m_tdata   // cursor, cell_char, cell_colour,
                                                  // scrolled, zero pad
);

  import tcw_pkg::*;

  logic                cmd_valid;
  cmd_t                cmd;
  logic                cmd_pop;
  logic                init_done;
  res_t                res;
  logic                ram_wr_en;
  logic [ADDR_W-1:0]   ram_wr_addr;
  logic [CELL_W-1:0]   ram_wr_data;
  logic [ADDR_W-1:0]   ram_rd_addr;
  logic [CELL_W-1:0]   ram_rd_data;

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .init_done (init_done),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tcw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .init_done   (init_done),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign m_tdata = {{M_PAD_W{1'b0}}, res.scrolled, res.cell_colour, res.cell_char,
                    res.cursor};

endmodule

### hdl/tcw_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/tcw_front.sv
`timescale 1ns / 1ps
// input side: takes items, decodes the action into a command, two-entry queue
// depends on tcw_pkg

module tcw_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tcw_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [tcw_pkg::S_TUSER_W-1:0]    s_tuser,
  input  logic                             init_done,
  output logic                             cmd_valid,
  output tcw_pkg::cmd_t                    cmd,
  input  logic                             cmd_pop
);

  import tcw_pkg::*;

  action_t             act;
  logic [BYTE_W-1:0]   code;
  logic [BYTE_W-1:0]   colour;
  logic [INDEX_W-1:0]  idx;
  cmd_t                dec;
  cmd_t                q [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;

  assign act    = action_t'(s_tuser);
  assign code   = s_tdata[BYTE_W-1:0];
  assign colour = s_tdata[2*BYTE_W-1:BYTE_W];
  assign idx    = s_tdata[2*BYTE_W+INDEX_W-1:2*BYTE_W];

  always_comb begin
    dec.char_code = code;
    dec.colour    = colour;
    dec.in_range  = (32'(idx) < CELLS);
    dec.pos       = dec.in_range ? POS_W'(idx) : POS_W'(CELLS - 1);
    unique case (act)
      ACT_PUT: begin
        if (code == NL_CODE) begin
          dec.kind = CMD_NEWLINE;
        end else if (code == CR_CODE) begin
          dec.kind = CMD_RETURN;
        end else begin
          dec.kind = CMD_PRINT;
        end
      end
      ACT_CLEAR: dec.kind = CMD_CLEAR;
      ACT_SET:   dec.kind = CMD_SET;
      ACT_READ:  dec.kind = CMD_READ;
    endcase
  end

  assign s_tready  = init_done && (count != 2'd2);
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/tcw_back.sv
`timescale 1ns / 1ps
// execution side: cursor, cell store sequencing (scroll, wipe), result register
// depends on tcw_pkg; drives the ports of a tcw_ram instance

module tcw_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  tcw_pkg::cmd_t                   cmd,
  output logic                            cmd_pop,
  output logic                            init_done,
  output logic                            res_valid,
  input  logic                            res_ready,
  output tcw_pkg::res_t                   res,
  output logic                            ram_wr_en,
  output logic [tcw_pkg::ADDR_W-1:0]      ram_wr_addr,
  output logic [tcw_pkg::CELL_W-1:0]      ram_wr_data,
  output logic [tcw_pkg::ADDR_W-1:0]      ram_rd_addr,
  input  logic [tcw_pkg::CELL_W-1:0]      ram_rd_data
);

  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_ZERO,
    ST_WIPE,
    ST_DIV,
    ST_RDWAIT
  } state_t;

  state_t              state;
  logic [POS_W-1:0]    cursor;
  logic [COL_W-1:0]    col;
  logic [ADDR_W-1:0]   cnt;
  logic [POS_W-1:0]    rem;
  logic                pend_valid;
  logic [ADDR_W-1:0]   pend_addr;
  logic                rd_ok;

  logic                out_free;
  logic [POS_W-1:0]    cur_adv;
  logic [COL_W-1:0]    col_adv;
  logic                wrap;

  assign out_free  = !res_valid || res_ready;
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid && out_free;
  assign init_done = (state != ST_INIT);

  // cursor movement for the put-character commands
  always_comb begin
    cur_adv = cursor;
    col_adv = col;
    case (cmd.kind)
      CMD_PRINT: begin
        cur_adv = cursor + POS_W'(1);
        col_adv = (col == COL_W'(COLUMNS - 1)) ? '0 : col + COL_W'(1);
      end
      CMD_NEWLINE: cur_adv = cursor + POS_W'(COLUMNS);
      CMD_RETURN: begin
        cur_adv = cursor - POS_W'(col);
        col_adv = '0;
      end
      default: begin
        cur_adv = cursor;
        col_adv = col;
      end
    endcase
    wrap = (cur_adv >= POS_W'(CELLS));
  end

  // a pending copy write wins over the zero fill of the last row
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = cnt;
    ram_wr_data = '0;
    if (pend_valid) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = pend_addr;
      ram_wr_data = ram_rd_data;
    end else if (state == ST_ZERO || state == ST_WIPE || state == ST_INIT) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = cnt;
    end else if (cmd_pop && cmd.kind == CMD_PRINT) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = ADDR_W'(cursor);
      ram_wr_data = {cmd.colour, cmd.char_code};
    end
  end

  assign ram_rd_addr = (state == ST_SCROLL) ? ADDR_W'(cnt + ADDR_W'(COLUMNS))
                                            : ADDR_W'(cmd.pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cursor     <= '0;
      col        <= '0;
      cnt        <= '0;
      rem        <= '0;
      pend_valid <= 1'b0;
      pend_addr  <= '0;
      rd_ok      <= 1'b0;
      res_valid  <= 1'b0;
      res        <= '0;
    end else begin
      pend_valid <= (state == ST_SCROLL);
      pend_addr  <= cnt;
      if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == ADDR_W'(CELLS - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_pop) begin
            case (cmd.kind)
              CMD_PRINT, CMD_NEWLINE, CMD_RETURN: begin
                col <= col_adv;
                if (wrap) begin
                  cursor <= cur_adv - POS_W'(COLUMNS);
                  cnt    <= '0;
                  state  <= ST_SCROLL;
                end else begin
                  cursor    <= cur_adv;
                  res_valid <= 1'b1;
                  res       <= '{cursor: CURSOR_W'(cur_adv), cell_char: '0,
                                 cell_colour: '0, scrolled: 1'b0};
                end
              end
              CMD_CLEAR: begin
                cursor <= '0;
                col    <= '0;
                cnt    <= '0;
                state  <= ST_WIPE;
              end
              CMD_SET: begin
                cursor <= cmd.pos;
                rem    <= cmd.pos;
                state  <= ST_DIV;
              end
              CMD_READ: begin
                rd_ok <= cmd.in_range;
                state <= ST_RDWAIT;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_SCROLL: begin
          // read one row ahead, write the data back in the next cycle
          cnt <= cnt + ADDR_W'(1);
          if (cnt == ADDR_W'(CELLS - COLUMNS - 1)) begin
            state <= ST_ZERO;
          end
        end
        ST_ZERO: begin
          if (!pend_valid) begin
            cnt <= cnt + ADDR_W'(1);
            if (cnt == ADDR_W'(CELLS - 1)) begin
              cnt       <= '0;
              state     <= ST_IDLE;
              res_valid <= 1'b1;
              res       <= '{cursor: CURSOR_W'(cursor), cell_char: '0,
                             cell_colour: '0, scrolled: 1'b1};
            end
          end
        end
        ST_WIPE: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == ADDR_W'(CELLS - 1)) begin
            cnt       <= '0;
            state     <= ST_IDLE;
            res_valid <= 1'b1;
            res       <= '{cursor: '0, cell_char: '0, cell_colour: '0, scrolled: 1'b0};
          end
        end
        ST_DIV: begin
          // column of the new cursor by repeated subtraction of a row
          if (rem >= POS_W'(COLUMNS)) begin
            rem <= rem - POS_W'(COLUMNS);
          end else begin
            col       <= COL_W'(rem);
            state     <= ST_IDLE;
            res_valid <= 1'b1;
            res       <= '{cursor: CURSOR_W'(cursor), cell_char: '0,
                           cell_colour: '0, scrolled: 1'b0};
          end
        end
        ST_RDWAIT: begin
          state     <= ST_IDLE;
          res_valid <= 1'b1;
          res.cursor      <= CURSOR_W'(cursor);
          res.cell_char   <= rd_ok ? ram_rd_data[BYTE_W-1:0] : '0;
          res.cell_colour <= rd_ok ? ram_rd_data[CELL_W-1:BYTE_W] : '0;
          res.scrolled    <= 1'b0;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/text_console_writer_test.sv
`timescale 1ns / 1ps
// self-checking bench for text_console_writer: a queue-fed stream driver, a result monitor
// and a cycle-free model of the cell store and cursor; depends on tcw_pkg and the block rtl

module text_console_writer_test;

  import tcw_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    action_t            act;
    logic [BYTE_W-1:0]  code;
    logic [BYTE_W-1:0]  attr;
    logic [INDEX_W-1:0] idx;
  } console_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  console_cmd_t cmd_q[$];
  res_t         expected_res_q[$];
  console_cmd_t drv_cmd;

  logic [CELL_W-1:0] screen_mem [CELLS];
  int cur_pos = 0;

  int src_wait = 0;
  int sink_wait = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_scrolls = 0;
  int n_reads = 0;
  int n_clears = 0;

  text_console_writer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
  end

  // every fourth run of 40 items goes without any idle cycles
  function automatic int idle_draw(int count);
    if ((count / 40) % 4 == 3) return 0;
    return $urandom_range(0, 7);
  endfunction

  function automatic void push_cmd(action_t act, logic [BYTE_W-1:0] code,
                                   logic [BYTE_W-1:0] attr, logic [INDEX_W-1:0] idx);
    console_cmd_t c;
    c.act  = act;
    c.code = code;
    c.attr = attr;
    c.idx  = idx;
    cmd_q.push_back(c);
  endfunction

  // applies one accepted item to the screen copy and queues the result it must give
  function automatic void console_step(console_cmd_t c);
    res_t r;
    r = '0;
    if (cur_pos >= CELLS) cur_pos = CELLS - 1;
    case (c.act)
      ACT_PUT: begin
        if (c.code == NL_CODE) begin
          cur_pos += COLUMNS;
        end else if (c.code == CR_CODE) begin
          cur_pos -= cur_pos % COLUMNS;
        end else begin
          screen_mem[cur_pos] = {c.attr, c.code};
          cur_pos += 1;
        end
        if (cur_pos >= CELLS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = '0;
          cur_pos -= COLUMNS;
          r.scrolled = 1'b1;
          n_scrolls++;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
        cur_pos = 0;
        n_clears++;
      end
      ACT_SET: begin
        cur_pos = (c.idx >= CELLS) ? CELLS - 1 : int'(c.idx);
      end
      default: begin
        if (c.idx < CELLS) begin
          r.cell_char   = screen_mem[c.idx][BYTE_W-1:0];
          r.cell_colour = screen_mem[c.idx][CELL_W-1:BYTE_W];
        end
        n_reads++;
      end
    endcase
    r.cursor = cur_pos[CURSOR_W-1:0];
    expected_res_q.push_back(r);
  endfunction

  // source side: one item held at a time, refilled from cmd_q after its idle draw
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait = 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        console_step(drv_cmd);
        n_accepted++;
        src_wait = idle_draw(n_accepted);
      end
      if (src_wait == 0 && cmd_q.size() != 0) begin
        drv_cmd = cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - INDEX_W - 2 * BYTE_W){1'b0}},
                     drv_cmd.idx, drv_cmd.attr, drv_cmd.code};
        s_tuser  <= drv_cmd.act;
      end else begin
        s_tvalid <= 1'b0;
        if (src_wait != 0) src_wait--;
      end
    end
  end

  // sink side: compare each result item against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        res_t exp_r;
        logic [CURSOR_W-1:0] got_cursor;
        logic [BYTE_W-1:0]   got_char;
        logic [BYTE_W-1:0]   got_colour;
        logic                got_scrolled;
        got_cursor   = m_tdata[CURSOR_W-1:0];
        got_char     = m_tdata[CURSOR_W +: BYTE_W];
        got_colour   = m_tdata[CURSOR_W + BYTE_W +: BYTE_W];
        got_scrolled = m_tdata[CURSOR_W + 2 * BYTE_W];
        n_results++;
        if (expected_res_q.size() == 0) begin
          $display("%0t unexpected result item: got %h", $time, m_tdata);
          n_errors++;
        end else begin
          exp_r = expected_res_q.pop_front();
          if (got_cursor !== exp_r.cursor) begin
            $display("%0t cursor mismatch: expected %0d got %0d",
                     $time, exp_r.cursor, got_cursor);
            n_errors++;
          end
          if (got_char !== exp_r.cell_char) begin
            $display("%0t cell_char mismatch: expected %h got %h",
                     $time, exp_r.cell_char, got_char);
            n_errors++;
          end
          if (got_colour !== exp_r.cell_colour) begin
            $display("%0t cell_colour mismatch: expected %h got %h",
                     $time, exp_r.cell_colour, got_colour);
            n_errors++;
          end
          if (got_scrolled !== exp_r.scrolled) begin
            $display("%0t scrolled mismatch: expected %b got %b",
                     $time, exp_r.scrolled, got_scrolled);
            n_errors++;
          end
        end
        sink_wait = idle_draw(n_results);
      end
      if (sink_wait == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        sink_wait--;
      end
    end
  end

  initial begin
    int n_directed;
    int seg;
    int base;
    int len;
    int pick;
    int rd;
    logic [BYTE_W-1:0] code;
    action_t act;

    // directed: fresh store, byte extremes, cr/nl, saturation, scroll paths, clear
    push_cmd(ACT_READ,  8'h00, 8'h00, 11'd0);
    push_cmd(ACT_PUT,   8'h00, 8'h00, 11'h7ff);
    push_cmd(ACT_PUT,   8'hff, 8'hff, 11'd0);
    push_cmd(ACT_PUT,   8'h41, 8'h1f, 11'd5);
    push_cmd(ACT_PUT,   CR_CODE, 8'hff, 11'h7ff);
    push_cmd(ACT_READ,  8'hff, 8'hff, 11'd0);
    push_cmd(ACT_READ,  8'h00, 8'h00, 11'd1);
    push_cmd(ACT_READ,  8'h00, 8'h00, 11'd2);
    push_cmd(ACT_PUT,   NL_CODE, 8'h55, 11'd0);
    push_cmd(ACT_SET,   8'hff, 8'hff, 11'h7ff);
    push_cmd(ACT_SET,   8'h00, 8'h00, 11'd2000);
    push_cmd(ACT_SET,   8'h00, 8'h00, 11'd1999);
    push_cmd(ACT_PUT,   8'h5a, 8'haa, 11'd0);
    push_cmd(ACT_READ,  8'h00, 8'h00, 11'd1999);
    push_cmd(ACT_READ,  8'h00, 8'h00, 11'd1919);
    push_cmd(ACT_READ,  8'h00, 8'h00, 11'd2000);
    push_cmd(ACT_READ,  8'hff, 8'hff, 11'h7ff);
    push_cmd(ACT_SET,   8'h00, 8'h00, 11'd1950);
    push_cmd(ACT_PUT,   NL_CODE, 8'h00, 11'd0);
    push_cmd(ACT_SET,   8'h00, 8'h00, 11'd1999);
    push_cmd(ACT_PUT,   CR_CODE, 8'h00, 11'd0);
    push_cmd(ACT_READ,  8'h00, 8'h00, 11'd1839);
    push_cmd(ACT_CLEAR, 8'hff, 8'hff, 11'h7ff);
    push_cmd(ACT_READ,  8'h00, 8'h00, 11'd1839);
    push_cmd(ACT_SET,   8'hff, 8'hff, 11'd0);
    n_directed = cmd_q.size();

    // random: mostly positioned runs of text followed by reads near them
    while (cmd_q.size() < n_directed + RANDOM_ITEMS) begin
      seg = $urandom_range(0, 99);
      if (seg < 72) begin
        base = ($urandom_range(0, 2) == 0) ? $urandom_range(1900, 2047)
                                           : $urandom_range(0, 2047);
        push_cmd(ACT_SET, BYTE_W'($urandom), BYTE_W'($urandom), INDEX_W'(base));
        len = $urandom_range(3, 12);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 15) code = NL_CODE;
          else if (pick < 25) code = CR_CODE;
          else code = BYTE_W'($urandom);
          push_cmd(ACT_PUT, code, BYTE_W'($urandom), INDEX_W'($urandom));
        end
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          // after a scroll the text sits one row higher
          rd = base + $urandom_range(0, 12) - ($urandom_range(0, 1) ? COLUMNS : 0);
          push_cmd(ACT_READ, BYTE_W'($urandom), BYTE_W'($urandom), INDEX_W'(rd));
        end
      end else if (seg < 97) begin
        pick = $urandom_range(0, 2);
        act = (pick == 0) ? ACT_PUT : (pick == 1) ? ACT_SET : ACT_READ;
        push_cmd(act, BYTE_W'($urandom), BYTE_W'($urandom), INDEX_W'($urandom));
      end else begin
        push_cmd(ACT_CLEAR, BYTE_W'($urandom), BYTE_W'($urandom), INDEX_W'($urandom));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_res_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d results: %0d scrolls, %0d reads, %0d clears",
             n_accepted, n_results, n_scrolls, n_reads, n_clears);
    if (n_errors == 0) begin
      $display("text_console_writer_test: done, clean");
    end else begin
      $display("text_console_writer_test: done, errors");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results still expected", expected_res_q.size());
    $display("text_console_writer_test: done, errors");
    $finish;
  end

endmodule

### filelist.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_front.sv
hdl/tcw_back.sv
hdl/text_console_writer.sv
tb/text_console_writer_test.sv
